/* sv/rfp_pkg.sv */
// Package for the reader frame parser: parser state, verdict and register types,
// error codes, register indexes and frame position constants.
// Depends on nothing; used by rfp_step and reader_frame_parser.
package rfp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned POS_W  = 9;
   localparam int unsigned ERR_W  = 3;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned RSP_DATA_W  = 56;
   localparam int unsigned RSP_USER_W  = 2;

   localparam logic [POS_W-1:0] POS_MAX             = 9'd511;
   localparam logic [POS_W-1:0] POS_LEN             = 9'd1;
   localparam logic [POS_W-1:0] POS_CODE            = 9'd2;
   localparam logic [POS_W-1:0] POS_DEVICE          = 9'd3;
   localparam logic [POS_W-1:0] POS_MIN_LAST        = 9'd4;
   localparam logic [POS_W-1:0] POS_NORMAL_PAYLOAD  = 9'd5;
   localparam logic [POS_W-1:0] POS_SPECIAL_FIRST   = 9'd2;
   localparam logic [POS_W-1:0] POS_SPECIAL_LAST_PL = 9'd14;
   localparam logic [POS_W-1:0] POS_SPECIAL_CHECK   = 9'd15;
   localparam logic [POS_W-1:0] POS_SPECIAL_LAST    = 9'd16;

   localparam logic [BYTE_W-1:0] SPECIAL_MARK = 8'h00;
   localparam logic [BYTE_W-1:0] SPECIAL_CODE = 8'hFF;
   localparam logic [BYTE_W-1:0] COUNT_MAX    = 8'hFF;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK           = 3'd0,
      ERR_TOO_SHORT    = 3'd1,
      ERR_SPECIAL_SIZE = 3'd2,
      ERR_CHECKSUM     = 3'd3,
      ERR_TYPE         = 3'd4,
      ERR_LENGTH       = 3'd5
   } err_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COMMAND_TYPE     = 2'd0,
      CSR_STATUS_TYPE      = 2'd1,
      CSR_INFORMATION_TYPE = 2'd2,
      CSR_UNUSED           = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] command_type_code;
      logic [BYTE_W-1:0] status_type_code;
      logic [BYTE_W-1:0] information_type_code;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0]  byte_position;
      logic [BYTE_W-1:0] running_sum;
      logic [BYTE_W-1:0] first_byte;
      logic [BYTE_W-1:0] len_byte;
      logic [BYTE_W-1:0] code_byte;
      logic [BYTE_W-1:0] device_byte;
      logic [BYTE_W-1:0] held_byte;
      logic              special_sum_ok;
      logic [BYTE_W-1:0] emitted_count;
   } state_type;

   typedef struct packed {
      logic              payload_valid;
      logic [BYTE_W-1:0] payload_byte;
      logic              frame_done;
      err_type           error_code;
      logic              is_special;
      logic [BYTE_W-1:0] frame_type;
      logic [BYTE_W-1:0] command_code;
      logic [BYTE_W-1:0] device_number;
      logic [BYTE_W-1:0] length_field;
      logic [BYTE_W-1:0] payload_count;
   } result_type;

endpackage

/* sv/reader_frame_parser.sv */
// Top level of the reader frame parser: handshakes, configuration registers,
// frame state and the result register. Depends on rfp_pkg and rfp_step.
//
// Usage. Frame bytes arrive on the req_ channel, one byte per beat, with
// req_tlast on the last byte of a frame. For every accepted byte exactly one
// result beat leaves on the rsp_ channel. A result beat carries a payload byte
// when rsp_tuser bit 0 is set, and the frame verdict when rsp_tlast is set;
// fields that are not meaningful in a beat read as zero.
// A byte accepted at a clock edge gives its result beat in rsp_tvalid from the
// next cycle on. The parser takes one byte per cycle while the receiver takes
// every beat; the frame state (position, running sum, header bytes, held
// byte) is computed by rfp_step and registered at the accepting edge, and the
// only other stage is the result register.
// When the receiver stalls, the result register holds its beat and req_tready
// falls, so no byte is taken until the waiting beat leaves; req_tready is high
// again in the same cycle that rsp_tready takes the beat.
// The csr_ channel writes the three frame type registers and is always ready;
// writes to the unused index are ignored. Write it only while no frame is in
// flight.
// Synchronous reset clears the frame state, empties the result register and
// loads the type registers with 1, 2 and 3.
module reader_frame_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata fields from bit 0: rx_byte[7:0]
   input  logic [rfp_pkg::BYTE_W-1:0]           req_tdata,
   input  logic                                 req_tlast,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata fields from bit 0: payload_byte[7:0], error_code[10:8],
   // frame_type[18:11], command_code[26:19], device_number[34:27],
   // length_field[42:35], payload_count[50:43], zero fill[55:51]
   output logic [rfp_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // rsp_tuser fields from bit 0: payload_valid, is_special
   output logic [rfp_pkg::RSP_USER_W-1:0]       rsp_tuser,
   // rsp_tlast carries frame_done
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rfp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rfp_pkg::BYTE_W-1:0]           csr_data
);
   import rfp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   result_type result_ff, result_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_fire;
   state_type  step_state;
   result_type step_result;

   // A new byte may enter whenever the result register is empty or is being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   rfp_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .rx_byte    (req_tdata),
      .frame_end  (req_tlast),
      .state_next (step_state),
      .result     (step_result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_COMMAND_TYPE:     cfg_in.command_type_code     = csr_data;
            CSR_STATUS_TYPE:      cfg_in.status_type_code      = csr_data;
            CSR_INFORMATION_TYPE: cfg_in.information_type_code = csr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   assign state_in     = req_fire ? step_state : state_ff;
   assign result_in    = req_fire ? step_result : result_ff;
   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_type_code     <= 8'd1;
         cfg_ff.status_type_code      <= 8'd2;
         cfg_ff.information_type_code <= 8'd3;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result payload needs no reset; rsp_tvalid qualifies it.
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = result_ff.frame_done;
   assign rsp_tuser  = {result_ff.is_special, result_ff.payload_valid};
   assign rsp_tdata  = {5'd0,
                        result_ff.payload_count,
                        result_ff.length_field,
                        result_ff.device_number,
                        result_ff.command_code,
                        result_ff.frame_type,
                        result_ff.error_code,
                        result_ff.payload_byte};

`ifndef SYNTHESIS
   // A byte that ends a frame leaves the parser at the start of the next frame.
   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> (state_ff.byte_position == '0) &&
                                (state_ff.emitted_count == '0))
      else $error("frame state not cleared after last byte");

   // Every accepted byte produces a result beat in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("accepted byte produced no result beat");

   // Verdict fields are zero in beats that do not end a frame.
   a_idle_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[50:8] == '0) && !rsp_tuser[1])
      else $error("verdict fields set without frame end");

   // A beat without payload carries a zero payload byte.
   a_idle_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[7:0] == '0)
      else $error("payload byte set without payload_valid");

   // The position counter holds at its top value while a long frame continues.
   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_tlast && state_ff.byte_position == POS_MAX
      |=> state_ff.byte_position == POS_MAX)
      else $error("byte position wrapped");
`endif

endmodule

/* sv/rfp_step.sv */
// Combinational step of the reader frame parser: takes one byte and the current
// parser state, gives the next state and the result beat. Uses rfp_pkg.
module rfp_step (
   input  rfp_pkg::state_type          state,
   input  rfp_pkg::cfg_type            cfg,
   input  logic [rfp_pkg::BYTE_W-1:0]  rx_byte,
   input  logic                        frame_end,
   output rfp_pkg::state_type          state_next,
   output rfp_pkg::result_type         result
);
   import rfp_pkg::*;

   logic [POS_W-1:0]  pos;
   logic [BYTE_W-1:0] first_b;
   logic [BYTE_W-1:0] len_b;
   logic [BYTE_W-1:0] code_b;
   logic [BYTE_W-1:0] dev_b;
   logic [BYTE_W-1:0] sum_incl;
   logic              special;
   logic              sum_ok;
   logic              emit;
   logic [BYTE_W-1:0] count;
   logic              type_ok;
   err_type           err;

   assign pos      = state.byte_position;
   assign first_b  = (pos == '0)         ? rx_byte : state.first_byte;
   assign len_b    = (pos == POS_LEN)    ? rx_byte : state.len_byte;
   assign code_b   = (pos == POS_CODE)   ? rx_byte : state.code_byte;
   assign dev_b    = (pos == POS_DEVICE) ? rx_byte : state.device_byte;
   assign special  = (first_b == SPECIAL_MARK);
   assign sum_incl = state.running_sum + rx_byte;

   // The special checksum is sampled at its own position and remembered for the trailer.
   assign sum_ok = (special && pos == POS_SPECIAL_CHECK) ? (sum_incl == '0)
                                                         : state.special_sum_ok;

   // Special frames stream the current byte; normal frames stream the held one,
   // so the checksum byte never leaves as payload.
   assign emit = special ? (pos >= POS_SPECIAL_FIRST && pos <= POS_SPECIAL_LAST_PL)
                         : (pos >= POS_NORMAL_PAYLOAD);
   assign count = (emit && state.emitted_count != COUNT_MAX) ? state.emitted_count + 8'd1
                                                             : state.emitted_count;

   assign type_ok = (first_b == cfg.command_type_code) ||
                    (first_b == cfg.status_type_code)  ||
                    (first_b == cfg.information_type_code);

   always_comb begin
      if (pos < POS_MIN_LAST) begin
         err = ERR_TOO_SHORT;
      end else if (special) begin
         if (pos != POS_SPECIAL_LAST) err = ERR_SPECIAL_SIZE;
         else if (!sum_ok)           err = ERR_CHECKSUM;
         else                        err = ERR_OK;
      end else begin
         if (sum_incl != '0)                      err = ERR_CHECKSUM;
         else if (!type_ok)                       err = ERR_TYPE;
         else if ({1'b0, len_b} != pos - 9'd1)    err = ERR_LENGTH;
         else                                     err = ERR_OK;
      end
   end

   always_comb begin
      result = '0;
      result.payload_valid = emit;
      result.payload_byte  = emit ? (special ? rx_byte : state.held_byte) : '0;
      if (frame_end) begin
         result.frame_done    = 1'b1;
         result.error_code    = err;
         result.is_special    = special;
         result.frame_type    = first_b;
         result.command_code  = special ? SPECIAL_CODE : code_b;
         result.device_number = special ? '0 : dev_b;
         result.length_field  = special ? '0 : len_b;
         result.payload_count = count;
      end
   end

   always_comb begin
      if (frame_end) begin
         state_next = '0;
      end else begin
         state_next.byte_position  = (pos != POS_MAX) ? pos + 9'd1 : pos;
         state_next.running_sum    = sum_incl;
         state_next.first_byte     = first_b;
         state_next.len_byte       = len_b;
         state_next.code_byte      = code_b;
         state_next.device_byte    = dev_b;
         state_next.held_byte      = rx_byte;
         state_next.special_sum_ok = sum_ok;
         state_next.emitted_count  = count;
      end
   end

endmodule
